>>> hw/rtl/nwbps_pkg.sv
// ----------------------------------------------------------------------------
// nwbps_pkg
// Shared types and constants of the nibble wildcard byte pattern search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nwbps_pkg;

    localparam int DATA_W    = 8;
    localparam int LEN_W     = 5;
    localparam int PAT_W     = 64;
    localparam int CARE_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int CFG_W     = 64;
    localparam int PAT_BYTES = 16;
    localparam int PIDX_W    = 4;

    localparam logic [DATA_W-1:0] NIB_LO = 8'h0F;
    localparam logic [DATA_W-1:0] NIB_HI = 8'hF0;

    typedef enum logic [1:0] {
        CFG_PATTERN_LEN  = 2'd0,
        CFG_PATTERN_LOW  = 2'd1,
        CFG_PATTERN_HIGH = 2'd2,
        CFG_CARE_MASK    = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        logic [DATA_W-1:0] pat;
        logic [DATA_W-1:0] mask;
    } t_pat_ref;

endpackage

`default_nettype wire

>>> hw/rtl/nwbps_in_if.sv
// ----------------------------------------------------------------------------
// nwbps_in_if
// Request channel carrying one buffer byte and its end-of-buffer flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface nwbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/nwbps_out_if.sv
// ----------------------------------------------------------------------------
// nwbps_out_if
// Result channel carrying the search outcome of one buffer.
// ----------------------------------------------------------------------------
`default_nettype none

interface nwbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/nibble_wildcard_byte_pattern_search_unit.sv
// ----------------------------------------------------------------------------
// nibble_wildcard_byte_pattern_search_unit
// Streaming first-match search of a byte pattern with nibble wildcards.
// ----------------------------------------------------------------------------
// The unit takes one byte per clock cycle, back to back, unless its result
// queue is full, and registers one result per buffer for the byte deciding
// it: found set with the start offset at the first match, or found clear on
// the last byte when nothing matched. A chain of MAX_PATTERN cells holds the
// recent bytes, and every cell compares its incoming byte in the same cycle,
// so the alignment ending at each byte is checked in full as it arrives. A
// two-entry result queue lets bytes keep flowing while a result waits to be
// taken. The user writes registers at the plain write port only while idle (not enforced).
`default_nettype none

module nibble_wildcard_byte_pattern_search_unit
    import nwbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    nwbps_in_if.sink               i_req,
    nwbps_out_if.source            o_rsp
);

    logic [LEN_W-1:0]   r_pattern_len;
    logic [PAT_W-1:0]   r_pattern_low;
    logic [PAT_W-1:0]   r_pattern_high;
    logic [CARE_W-1:0]  r_care_mask;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_done;
    logic               n_done;

    logic               r_q_found [2];
    logic [COUNT_W-1:0] r_q_offset [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_q_count;

    logic [LEN_W-1:0]   len_eff;
    logic [DATA_W-1:0]  pat_bytes [PAT_BYTES];
    logic [DATA_W-1:0]  chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] hits;
    t_cell_ctrl         ctrl;

    logic               accept;
    logic               active;
    logic               match;
    logic               emit;
    logic               pop;
    logic [COUNT_W-1:0] count_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_len  <= LEN_W'(1);
            r_pattern_low  <= '0;
            r_pattern_high <= '0;
            r_care_mask    <= '1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_LEN:  r_pattern_len  <= i_cfg_data[LEN_W-1:0];
                CFG_PATTERN_LOW:  r_pattern_low  <= i_cfg_data[PAT_W-1:0];
                CFG_PATTERN_HIGH: r_pattern_high <= i_cfg_data[PAT_W-1:0];
                CFG_CARE_MASK:    r_care_mask    <= i_cfg_data[CARE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        len_eff = r_pattern_len;
        if (r_pattern_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_pattern_len > LEN_W'(MAX_PATTERN)) begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
    end

    for (genvar b = 0; b < PAT_BYTES; b++) begin : g_pat
        if (b < PAT_BYTES / 2) begin : g_lo
            assign pat_bytes[b] = r_pattern_low[b*DATA_W +: DATA_W];
        end else begin : g_hi
            assign pat_bytes[b] = r_pattern_high[(b - PAT_BYTES/2)*DATA_W +: DATA_W];
        end
    end

    assign accept = i_req.valid && i_req.ready;
    assign active = accept && !r_done;
    assign ctrl.shift = active;
    assign ctrl.clear = accept && i_req.last_byte;
    assign chain[0] = i_req.data_byte;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic [PIDX_W-1:0] idx;
        t_pat_ref          cref;
        logic              cen;

        assign idx  = PIDX_W'(len_eff - LEN_W'(1) - LEN_W'(j));
        assign cen  = LEN_W'(j) < len_eff;
        assign cref.pat  = pat_bytes[idx];
        assign cref.mask = (r_care_mask[{idx, 1'b0}] ? NIB_LO : '0)
                         | (r_care_mask[{idx, 1'b1}] ? NIB_HI : '0);

        nwbps_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_shift_in (chain[j]),
            .i_ref      (cref),
            .i_en       (cen),
            .o_byte     (chain[j+1]),
            .o_hit      (hits[j])
        );
    end

    assign count_inc = (r_count == '1) ? r_count : r_count + COUNT_W'(1);
    assign match = active && (count_inc >= COUNT_W'(len_eff)) && (&hits);
    assign emit  = match || (active && i_req.last_byte);

    always_comb begin
        n_count = r_count;
        n_done  = r_done;
        if (accept) begin
            if (i_req.last_byte) begin
                n_count = '0;
                n_done  = 1'b0;
            end else if (active) begin
                n_count = count_inc;
                n_done  = match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    assign pop = o_rsp.valid && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_q_found[r_wr_ptr]  <= match;
            r_q_offset[r_wr_ptr] <= match ? (count_inc - COUNT_W'(len_eff)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= 1'b0;
            r_rd_ptr  <= 1'b0;
            r_q_count <= '0;
        end else begin
            if (emit) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_q_count <= r_q_count + 2'(emit) - 2'(pop);
        end
    end

    assign i_req.ready        = (r_q_count != 2'd2);
    assign o_rsp.valid        = (r_q_count != '0);
    assign o_rsp.found        = r_q_found[r_rd_ptr];
    assign o_rsp.match_offset = r_q_offset[r_rd_ptr];

endmodule

`default_nettype wire

>>> hw/rtl/nwbps_cell.sv
// ----------------------------------------------------------------------------
// nwbps_cell
// One window cell: holds a byte, passes it on, and compares the incoming byte.
// ----------------------------------------------------------------------------
`default_nettype none

module nwbps_cell
    import nwbps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic [DATA_W-1:0] i_shift_in,
    input  wire t_pat_ref          i_ref,
    input  wire logic              i_en,
    output logic [DATA_W-1:0]      o_byte,
    output logic                   o_hit
);

    logic [DATA_W-1:0] r_byte;
    logic [DATA_W-1:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.clear) begin
            n_byte = '0;
        end else if (i_ctrl.shift) begin
            n_byte = i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_en || (((i_shift_in ^ i_ref.pat) & i_ref.mask) == '0);

endmodule

`default_nettype wire
